FILE: hdl/ghps_pkg.sv
// Package with types, constants and helpers of the heading-hold steering controller.
package ghps_pkg;

  localparam int KindW   = 2;
  localparam int RateW   = 16;
  localparam int StepW   = 17;
  localparam int DutyW   = 16;
  localparam int HeadW   = 34;
  localparam int IntW    = 33;
  localparam int GainW   = 24;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 31;
  localparam int MulAW   = 35;
  localparam int MulBW   = 25;
  localparam int ProdW   = MulAW + MulBW;
  localparam int AccW    = 64;

  localparam logic [StepW-1:0] MaxStep = 17'd104858;
  localparam logic signed [HeadW:0] HalfTurn = 35'sd3019898880;
  localparam logic signed [HeadW:0] FullTurn = 35'sd6039797760;

  typedef enum logic [KindW-1:0] {
    KIND_UPDATE = 2'd0,
    KIND_START  = 2'd1,
    KIND_STOP   = 2'd2,
    KIND_SET    = 2'd3
  } kind_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KP     = 3'd0,
    REG_KI     = 3'd1,
    REG_KR     = 3'd2,
    REG_DBAND  = 3'd3,
    REG_IBOUND = 3'd4,
    REG_CBOUND = 3'd5,
    REG_DBOUND = 3'd6
  } reg_idx_t;

  // One wrap step is enough: both operands already lie within a half turn
  // plus at most one more turn.
  function automatic logic signed [HeadW-1:0] wrap_angle(input logic signed [HeadW:0] a);
    logic signed [HeadW:0] r;
    r = a;
    if (a > HalfTurn) begin
      r = a - FullTurn;
    end else if (a < -HalfTurn) begin
      r = a + FullTurn;
    end
    return r[HeadW-1:0];
  endfunction

endpackage

FILE: hdl/ghps_in_if.sv
// Input channel interface of the steering controller.
interface ghps_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [ghps_pkg::KindW-1:0]           kind;
  logic signed [ghps_pkg::RateW-1:0]    yaw_rate;
  logic [ghps_pkg::StepW-1:0]           time_step;
  logic signed [ghps_pkg::DutyW-1:0]    duty_request;

  modport source (output valid, kind, yaw_rate, time_step, duty_request, input ready);
  modport sink   (input valid, kind, yaw_rate, time_step, duty_request, output ready);
endinterface

FILE: hdl/ghps_out_if.sv
// Result channel interface of the steering controller.
interface ghps_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 ok;
  logic signed [ghps_pkg::DutyW-1:0]    duty_left;
  logic signed [ghps_pkg::DutyW-1:0]    duty_right;
  logic                                 running;
  logic signed [ghps_pkg::DutyW-1:0]    heading_now;

  modport source (output valid, ok, duty_left, duty_right, running, heading_now, input ready);
  modport sink   (input valid, ok, duty_left, duty_right, running, heading_now, output ready);
endinterface

FILE: hdl/gyro_heading_pi_steering_top.sv
// Heading-hold PI steering controller with one shared multiplier and a sequencer.
//
//   channel | direction | contents
//   in_ch   | sink      | kind, yaw_rate, time_step, duty_request
//   out_ch  | source    | ok, duty_left, duty_right, running, heading_now
//   cfg_*   | write     | seven gain and bound registers by index
//
// Start, stop, set-duty and rejected updates show their result in the cycle after
// acceptance; a disabled update passes through MH and HD, an enabled update through MH,
// HD, ER, ME, CA, MP, MI, MR, AC and FN, before ST_OUT. The shared 35x25 multiplier, used
// five times in turn, sets the length of an update. One transaction is in flight at a
// time; in_ch.ready is low until the result is taken. A stalled result holds its payload.
// Reset is synchronous and covers the sequencer, controller and config registers only.
module gyro_heading_pi_steering_top (
  input  logic                         clk,
  input  logic                         rst_n,
  ghps_in_if.sink                      in_ch,
  ghps_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [ghps_pkg::CfgIdxW-1:0] cfg_idx,
  input  logic [ghps_pkg::CfgW-1:0]    cfg_wdata
);

  typedef enum logic [11:0] {
    ST_IDLE = 12'b000000000001,
    ST_MH   = 12'b000000000010,
    ST_HD   = 12'b000000000100,
    ST_ER   = 12'b000000001000,
    ST_ME   = 12'b000000010000,
    ST_CA   = 12'b000000100000,
    ST_MP   = 12'b000001000000,
    ST_MI   = 12'b000010000000,
    ST_MR   = 12'b000100000000,
    ST_AC   = 12'b001000000000,
    ST_FN   = 12'b010000000000,
    ST_OUT  = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic signed [ghps_pkg::GainW-1:0] kp_r, ki_r, kr_r;
  logic [14:0] dband_r, cbound_r, dbound_r;
  logic [30:0] ibound_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r     <= '0;
      ki_r     <= '0;
      kr_r     <= '0;
      dband_r  <= '0;
      ibound_r <= '0;
      cbound_r <= '0;
      dbound_r <= 15'd32767;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        ghps_pkg::REG_KP:     kp_r     <= cfg_wdata[23:0];
        ghps_pkg::REG_KI:     ki_r     <= cfg_wdata[23:0];
        ghps_pkg::REG_KR:     kr_r     <= cfg_wdata[23:0];
        ghps_pkg::REG_DBAND:  dband_r  <= cfg_wdata[14:0];
        ghps_pkg::REG_IBOUND: ibound_r <= cfg_wdata[30:0];
        ghps_pkg::REG_CBOUND: cbound_r <= cfg_wdata[14:0];
        ghps_pkg::REG_DBOUND: dbound_r <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // Controller state and working registers.
  logic signed [ghps_pkg::HeadW-1:0] heading_r, heading_nxt;
  logic signed [ghps_pkg::HeadW-1:0] target_r, target_nxt;
  logic signed [ghps_pkg::IntW-1:0]  integ_r, integ_nxt;
  logic                              en_r, en_nxt;
  logic signed [ghps_pkg::DutyW-1:0] base_r, base_nxt;
  logic signed [ghps_pkg::RateW-1:0] rate_r, rate_nxt;
  logic [ghps_pkg::StepW-1:0]        step_r, step_nxt;
  logic signed [ghps_pkg::HeadW-1:0] err_r, err_nxt;
  logic signed [ghps_pkg::IntW-1:0]  cand_r, cand_nxt;
  logic signed [ghps_pkg::ProdW-1:0] prod_r, prod_nxt;
  logic signed [ghps_pkg::AccW-1:0]  acc_r, acc_nxt;
  logic                              ok_r, ok_nxt;
  logic signed [ghps_pkg::DutyW-1:0] left_r, left_nxt, right_r, right_nxt;

  // Shared multiplier operands.
  logic signed [ghps_pkg::MulAW-1:0] mul_a;
  logic signed [ghps_pkg::MulBW-1:0] mul_b;

  logic signed [16:0] rate_mag;
  logic signed [16:0] dbound_s, clamped_req;
  logic signed [35:0] err_step_rnd;
  logic signed [36:0] cand_raw, ib_s;
  logic signed [42:0] u_val;
  logic signed [42:0] cb_s;
  logic signed [16:0] corr;
  logic signed [16:0] left_raw, right_raw;
  logic signed [ghps_pkg::AccW-1:0] acc_rnd;
  logic               unsat;
  logic signed [ghps_pkg::HeadW:0] head_rnd;

  always_comb begin
    dbound_s = $signed({2'b00, dbound_r});
    if ($signed({in_ch.duty_request[15], in_ch.duty_request}) > dbound_s) begin
      clamped_req = dbound_s;
    end else if ($signed({in_ch.duty_request[15], in_ch.duty_request}) < -dbound_s) begin
      clamped_req = -dbound_s;
    end else begin
      clamped_req = {in_ch.duty_request[15], in_ch.duty_request};
    end
    rate_mag = in_ch.yaw_rate[15] ? -$signed({1'b1, in_ch.yaw_rate})
                                  : $signed({1'b0, in_ch.yaw_rate});

    err_step_rnd = 36'((prod_r + (ghps_pkg::ProdW'(1) <<< 23)) >>> 24);
    cand_raw = 37'(integ_r) + 37'(err_step_rnd);
    ib_s     = $signed({6'd0, ibound_r});

    acc_rnd = (acc_r + (ghps_pkg::AccW'(1) <<< 20)) >>> 21;
    u_val   = acc_rnd[42:0];
    cb_s    = $signed({28'd0, cbound_r});
    if (u_val > cb_s) begin
      corr = $signed({2'b00, cbound_r});
    end else if (u_val < -cb_s) begin
      corr = -$signed({2'b00, cbound_r});
    end else begin
      corr = u_val[16:0];
    end
    unsat = (u_val <= cb_s) && (u_val >= -cb_s);
    left_raw  = 17'(base_r) - corr;
    right_raw = 17'(base_r) + corr;

    head_rnd = (35'(heading_r) + 35'sd65536) >>> 17;

    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_MH: begin
        mul_a = 35'(rate_r);
        mul_b = $signed({8'd0, step_r});
      end
      ST_ME: begin
        mul_a = 35'(err_r);
        mul_b = $signed({8'd0, step_r});
      end
      ST_MP: begin
        mul_a = 35'(err_r);
        mul_b = 25'(kp_r);
      end
      ST_MI: begin
        mul_a = 35'(cand_r);
        mul_b = 25'(ki_r);
      end
      ST_MR: begin
        mul_a = 35'(rate_r);
        mul_b = 25'(kr_r);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    heading_nxt = heading_r;
    target_nxt  = target_r;
    integ_nxt   = integ_r;
    en_nxt      = en_r;
    base_nxt    = base_r;
    rate_nxt    = rate_r;
    step_nxt    = step_r;
    err_nxt     = err_r;
    cand_nxt    = cand_r;
    prod_nxt    = mul_a * mul_b;
    acc_nxt     = acc_r;
    ok_nxt      = ok_r;
    left_nxt    = left_r;
    right_nxt   = right_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          ok_nxt    = 1'b1;
          left_nxt  = '0;
          right_nxt = '0;
          rate_nxt  = (rate_mag < $signed({2'b00, dband_r})) ? '0 : in_ch.yaw_rate;
          step_nxt  = in_ch.time_step;
          state_nxt = ST_OUT;
          unique case (ghps_pkg::kind_t'(in_ch.kind))
            ghps_pkg::KIND_UPDATE: begin
              if (in_ch.time_step == '0 || in_ch.time_step > ghps_pkg::MaxStep) begin
                ok_nxt = 1'b0;
              end else begin
                state_nxt = ST_MH;
              end
            end
            ghps_pkg::KIND_START: begin
              base_nxt   = clamped_req[15:0];
              target_nxt = heading_r;
              integ_nxt  = '0;
              en_nxt     = 1'b1;
            end
            ghps_pkg::KIND_STOP: begin
              en_nxt    = 1'b0;
              integ_nxt = '0;
            end
            ghps_pkg::KIND_SET: begin
              base_nxt = clamped_req[15:0];
            end
            default: ;
          endcase
        end
      end
      ST_MH: state_nxt = ST_HD;
      ST_HD: begin
        heading_nxt = ghps_pkg::wrap_angle(35'(heading_r) + $signed(prod_r[34:0]));
        state_nxt   = en_r ? ST_ER : ST_OUT;
      end
      ST_ER: begin
        err_nxt   = ghps_pkg::wrap_angle(35'(target_r) - 35'(heading_r));
        state_nxt = ST_ME;
      end
      ST_ME: state_nxt = ST_CA;
      ST_CA: begin
        if (cand_raw > ib_s) begin
          cand_nxt = ib_s[32:0];
        end else if (cand_raw < -ib_s) begin
          cand_nxt = 33'(-ib_s);
        end else begin
          cand_nxt = cand_raw[32:0];
        end
        state_nxt = ST_MP;
      end
      ST_MP: state_nxt = ST_MI;
      ST_MI: begin
        acc_nxt   = 64'(prod_r);
        state_nxt = ST_MR;
      end
      ST_MR: begin
        acc_nxt   = acc_r + (64'(prod_r) <<< 4);
        state_nxt = ST_AC;
      end
      ST_AC: begin
        acc_nxt   = acc_r - (64'(prod_r) <<< 20);
        state_nxt = ST_FN;
      end
      ST_FN: begin
        // Conditional integration: keep the new integral unless saturated and
        // the error pushes further into saturation.
        if (unsat || (u_val > 43'(corr) && err_r < 0) || (u_val < 43'(corr) && err_r > 0)) begin
          integ_nxt = cand_r;
        end
        if (left_raw > dbound_s) begin
          left_nxt = dbound_s[15:0];
        end else if (left_raw < -dbound_s) begin
          left_nxt = 16'(-dbound_s);
        end else begin
          left_nxt = left_raw[15:0];
        end
        if (right_raw > dbound_s) begin
          right_nxt = dbound_s[15:0];
        end else if (right_raw < -dbound_s) begin
          right_nxt = 16'(-dbound_s);
        end else begin
          right_nxt = right_raw[15:0];
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      heading_r <= '0;
      target_r  <= '0;
      integ_r   <= '0;
      en_r      <= 1'b0;
      base_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      heading_r <= heading_nxt;
      target_r  <= target_nxt;
      integ_r   <= integ_nxt;
      en_r      <= en_nxt;
      base_r    <= base_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rate_r  <= rate_nxt;
    step_r  <= step_nxt;
    err_r   <= err_nxt;
    cand_r  <= cand_nxt;
    prod_r  <= prod_nxt;
    acc_r   <= acc_nxt;
    ok_r    <= ok_nxt;
    left_r  <= left_nxt;
    right_r <= right_nxt;
  end

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = (state_r == ST_OUT);
  assign out_ch.ok          = ok_r;
  assign out_ch.duty_left   = left_r;
  assign out_ch.duty_right  = right_r;
  assign out_ch.running     = en_r;
  assign out_ch.heading_now = head_rnd[15:0];

endmodule

FILE: hdl/ghps_chk.sv
// Port-level checker of the steering controller and its bind to the top level.
module ghps_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        ok,
  input logic        running,
  input logic [15:0] duty_left,
  input logic [15:0] duty_right
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready again right after a transaction");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !ok |-> duty_left == '0 && duty_right == '0)
    else $error("rejected update shows nonzero duty");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !running |-> duty_left == '0 && duty_right == '0)
    else $error("disabled controller shows nonzero duty");

endmodule

bind gyro_heading_pi_steering_top ghps_chk u_ghps_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .ok         (out_ch.ok),
  .running    (out_ch.running),
  .duty_left  (out_ch.duty_left),
  .duty_right (out_ch.duty_right)
);

FILE: tb/ghps_checker.sv
// Checker that predicts the steering controller's results and compares them on the result channel.
`timescale 1ns / 1ps
module ghps_checker (
  input  logic            clk,
  input  logic            rst_n,
  ghps_in_if              in_ch,
  ghps_out_if             out_ch,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_idx,
  input  logic [30:0]     cfg_wdata,
  output int              fail_count,
  output int              pending
);

  typedef struct packed {
    logic        ok;
    logic [15:0] duty_left;
    logic [15:0] duty_right;
    logic        running;
    logic [15:0] heading_now;
  } steer_result_t;

  localparam longint Half = 64'sd3019898880;
  localparam longint Full = 64'sd6039797760;

  steer_result_t expected_results[$];
  longint kp_q, ki_q, kr_q, dband_q, ibound_q, cbound_q, dbound_q;
  longint heading_q, target_q, integral_q, base_q;
  bit     enabled_q;

  function automatic longint sx(longint v, int w);
    longint m;
    m = (64'sd1 <<< w) - 1;
    v = v & m;
    if (v[w-1]) v = v - (64'sd1 <<< w);
    return v;
  endfunction

  // Arithmetic shift is a floor for signed longint.
  function automatic longint rnd_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint wrap_deg(longint a);
    while (a > Half) a -= Full;
    while (a < -Half) a += Full;
    return a;
  endfunction

  function automatic steer_result_t predict_steering(ghps_pkg::kind_t kind, longint rate,
                                                      longint step, longint req);
    steer_result_t r;
    longint left, right, err, cand, sum, u, corr, mag;
    left = 0;
    right = 0;
    r.ok = 1'b1;
    case (kind)
      ghps_pkg::KIND_UPDATE: begin
        if (step == 0 || step > 104858) begin
          r.ok = 1'b0;
        end else begin
          mag = rate < 0 ? -rate : rate;
          if (mag < dband_q) rate = 0;
          heading_q = wrap_deg(heading_q + rate * step);
          if (enabled_q) begin
            err = wrap_deg(target_q - heading_q);
            cand = clip(integral_q + rnd_shift(err * step, 24), -ibound_q, ibound_q);
            sum = kp_q * err + ki_q * cand * 16 - kr_q * rate * (64'sd1 <<< 20);
            u = rnd_shift(sum, 21);
            corr = clip(u, -cbound_q, cbound_q);
            if ((u >= -cbound_q && u <= cbound_q) || (u > corr && err < 0) ||
                (u < corr && err > 0)) integral_q = cand;
            left = clip(base_q - corr, -dbound_q, dbound_q);
            right = clip(base_q + corr, -dbound_q, dbound_q);
          end
        end
      end
      ghps_pkg::KIND_START: begin
        base_q = clip(req, -dbound_q, dbound_q);
        target_q = heading_q;
        integral_q = 0;
        enabled_q = 1'b1;
      end
      ghps_pkg::KIND_STOP: begin
        enabled_q = 1'b0;
        integral_q = 0;
      end
      default: base_q = clip(req, -dbound_q, dbound_q);
    endcase
    r.duty_left = left[15:0];
    r.duty_right = right[15:0];
    r.running = enabled_q;
    r.heading_now = 16'(rnd_shift(heading_q, 17));
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    steer_result_t got, want;
    if (!rst_n) begin
      kp_q = 0; ki_q = 0; kr_q = 0; dband_q = 0; ibound_q = 0; cbound_q = 0;
      dbound_q = 32767;
      heading_q = 0; target_q = 0; integral_q = 0; base_q = 0; enabled_q = 0;
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (ghps_pkg::reg_idx_t'(cfg_idx))
          ghps_pkg::REG_KP:     kp_q = sx(cfg_wdata, 24);
          ghps_pkg::REG_KI:     ki_q = sx(cfg_wdata, 24);
          ghps_pkg::REG_KR:     kr_q = sx(cfg_wdata, 24);
          ghps_pkg::REG_DBAND:  dband_q = cfg_wdata[14:0];
          ghps_pkg::REG_IBOUND: ibound_q = cfg_wdata;
          ghps_pkg::REG_CBOUND: cbound_q = cfg_wdata[14:0];
          ghps_pkg::REG_DBOUND: dbound_q = cfg_wdata[14:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        expected_results.push_back(predict_steering(ghps_pkg::kind_t'(in_ch.kind),
                                                    in_ch.yaw_rate, in_ch.time_step,
                                                    in_ch.duty_request));
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.ok, out_ch.duty_left, out_ch.duty_right, out_ch.running,
                out_ch.heading_now};
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result transaction %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display({"mismatch: expected ok=%0d l=%0d r=%0d run=%0d hd=%0d, ",
                        "got ok=%0d l=%0d r=%0d run=%0d hd=%0d"},
                       want.ok, $signed(want.duty_left), $signed(want.duty_right),
                       want.running, $signed(want.heading_now), got.ok,
                       $signed(got.duty_left), $signed(got.duty_right), got.running,
                       $signed(got.heading_now));
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

FILE: tb/testbench.sv
// Top of the steering controller testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [30:0] cfg_wdata = '0;
  int          fail_count;
  int          pending;
  int          burst_left = 0;
  longint      cycle_count = 0;

  ghps_in_if  in_ch();
  ghps_out_if out_ch();

  gyro_heading_pi_steering_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  ghps_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_we(cfg_we),
    .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata), .fail_count(fail_count), .pending(pending)
  );

  always #5 clk = ~clk;

  // Receiver stall pattern: long open stretches alternate with random stalls.
  always @(negedge clk) begin
    if (cycle_count[9:8] == 2'd0) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 600000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(ghps_pkg::reg_idx_t idx, logic [30:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  // Sends one transaction; called at a falling edge, returns at a falling edge.
  // Valid stays high inside a burst and drops only at its end.
  task automatic send_item(ghps_pkg::kind_t kind, logic [15:0] rate, logic [16:0] step,
                           logic [15:0] req);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.yaw_rate <= rate;
    in_ch.time_step <= step;
    in_ch.duty_request <= req;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    if (burst_left == 0) in_ch.valid <= 1'b0;
  endtask

  function automatic logic [16:0] pick_step();
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return 17'($urandom_range(104859, 131071));
      2: return 17'($urandom_range(1, 3));
      3: return 17'd104858;
      default: return 17'($urandom_range(1, 104858));
    endcase
  endfunction

  task automatic random_phase(int count);
    int r;
    repeat (count) begin
      r = $urandom_range(0, 19);
      if (r == 0)
        send_item(ghps_pkg::KIND_START, 16'($urandom), 17'($urandom), 16'($urandom));
      else if (r == 1)
        send_item(ghps_pkg::KIND_STOP, 16'($urandom), 17'($urandom), 16'($urandom));
      else if (r == 2)
        send_item(ghps_pkg::KIND_SET, 16'($urandom), 17'($urandom), 16'($urandom));
      else
        send_item(ghps_pkg::KIND_UPDATE, 16'($urandom), pick_step(), 16'($urandom));
    end
  endtask

  task automatic set_gains(logic [23:0] kp, logic [23:0] ki, logic [23:0] kr,
                           logic [14:0] db, logic [30:0] ib, logic [14:0] cb,
                           logic [14:0] dub);
    write_reg(ghps_pkg::REG_KP, 31'(kp));
    write_reg(ghps_pkg::REG_KI, 31'(ki));
    write_reg(ghps_pkg::REG_KR, 31'(kr));
    write_reg(ghps_pkg::REG_DBAND, 31'(db));
    write_reg(ghps_pkg::REG_IBOUND, ib);
    write_reg(ghps_pkg::REG_CBOUND, 31'(cb));
    write_reg(ghps_pkg::REG_DBOUND, 31'(dub));
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = ghps_pkg::KIND_UPDATE;
    in_ch.yaw_rate = '0;
    in_ch.time_step = '0;
    in_ch.duty_request = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // Directed part under reset settings, then typical gains.
    send_item(ghps_pkg::KIND_UPDATE, 16'sd100, 17'd0, 16'sd0);
    send_item(ghps_pkg::KIND_UPDATE, 16'sd100, 17'd104859, 16'sd0);
    send_item(ghps_pkg::KIND_UPDATE, 16'h7fff, 17'd104858, 16'sd0);
    send_item(ghps_pkg::KIND_START, 16'sd0, 17'd0, 16'h7fff);
    send_item(ghps_pkg::KIND_UPDATE, 16'h8000, 17'd104858, 16'sd0);
    send_item(ghps_pkg::KIND_UPDATE, 16'h7fff, 17'd1, 16'sd0);
    send_item(ghps_pkg::KIND_SET, 16'sd0, 17'd0, 16'h8000);
    send_item(ghps_pkg::KIND_STOP, 16'sd0, 17'd0, 16'sd0);
    send_item(ghps_pkg::KIND_UPDATE, 16'h8000, 17'h1ffff, 16'sd0);
    wait_drained();
    set_gains(24'h004000, 24'h000800, 24'h000100, 15'd16, 31'd50000000, 15'd8000, 15'd20000);
    send_item(ghps_pkg::KIND_START, 16'sd0, 17'd0, 16'sd12000);
    repeat (8) send_item(ghps_pkg::KIND_UPDATE, 16'h7fff, 17'd104858, 16'sd0);
    send_item(ghps_pkg::KIND_UPDATE, 16'sd15, 17'd50000, 16'sd0);
    send_item(ghps_pkg::KIND_UPDATE, -16'sd15, 17'd50000, 16'sd0);
    send_item(ghps_pkg::KIND_SET, 16'sd0, 17'd0, 16'h7fff);
    send_item(ghps_pkg::KIND_UPDATE, 16'h8000, 17'd104858, 16'sd0);
    random_phase(250);
    wait_drained();
    // Extreme gains, zero duty bound.
    set_gains(24'h7fffff, 24'h800000, 24'h7fffff, 15'h7fff, 31'h7fffffff, 15'h7fff, 15'd0);
    random_phase(150);
    wait_drained();
    set_gains(24'h800000, 24'h7fffff, 24'h800000, 15'd0, 31'd0, 15'd0, 15'd1);
    random_phase(100);
    wait_drained();
    // Base duty above a later, smaller bound.
    write_reg(ghps_pkg::REG_DBOUND, 31'h7fff);
    send_item(ghps_pkg::KIND_SET, 16'sd0, 17'd0, 16'sd30000);
    wait_drained();
    set_gains(24'($urandom), 24'($urandom), 24'($urandom), 15'($urandom_range(0, 200)),
              31'($urandom), 15'($urandom), 15'd5000);
    random_phase(400);
    wait_drained();
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
